### hdl/rkf_pkg.sv
package rkf_pkg;

   // Image geometry limits
   localparam int MaxWidth  = 4096;
   localparam int MaxHeight = 4096;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);

   // Field widths fixed by the register and channel definitions
   localparam int ChanW    = 8;
   localparam int CoordW   = 12;
   localparam int DimW     = 13;
   localparam int SelW     = 12;
   localparam int ModeW    = 2;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 13;

   // Kernel arithmetic
   localparam int SumW     = 14;
   localparam int CoefW    = 5;
   localparam int RecipW   = 13;
   localparam int ProdW    = 26;
   localparam int BoxShift = 16;
   localparam logic [RecipW-1:0] BoxRecip = 13'd7282;  // ceil(2^16 / 9)

   // Filter modes
   localparam logic [ModeW-1:0] ModeEdge    = 2'd0;
   localparam logic [ModeW-1:0] ModeSharpen = 2'd1;
   localparam logic [ModeW-1:0] ModeBox     = 2'd2;
   localparam logic [ModeW-1:0] ModeGauss   = 2'd3;

   // Register indexes
   localparam logic [CsrIdxW-1:0] RegFilterMode  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegImageWidth  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegImageHeight = 3'd2;
   localparam logic [CsrIdxW-1:0] RegSelLeft     = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSelTop      = 3'd4;
   localparam logic [CsrIdxW-1:0] RegSelRight    = 3'd5;
   localparam logic [CsrIdxW-1:0] RegSelBottom   = 3'd6;

   typedef logic signed [CoefW-1:0] coef_type;

   // Rows: edge, sharpen, box, gaussian; taps in raster order of the window
   localparam coef_type KernelTable [4][9] = '{
      '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
      '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
      '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
      '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1}
   };

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } pixel_type;

   localparam int PixW = $bits(pixel_type);

   typedef struct packed {
      logic [ModeW-1:0] filter_mode;
      logic [DimW-1:0]  image_width;
      logic [DimW-1:0]  image_height;
      logic [SelW-1:0]  sel_left;
      logic [SelW-1:0]  sel_top;
      logic [DimW-1:0]  sel_right;
      logic [DimW-1:0]  sel_bottom;
   } cfg_type;

   // Position of the arriving pixel and which results it causes
   typedef struct packed {
      logic            filt_prev;  // upper-left neighbor completes a filtered pixel
      logic            filt_cur;   // this pixel is filtered, so not passed through now
      logic [RowW-1:0] row;
      logic [ColW-1:0] col;
   } scan_type;

endpackage

### hdl/rkf_req_if.sv
interface rkf_req_if import rkf_pkg::*;;
   logic             valid;
   logic             ready;
   logic [ChanW-1:0] pix_red;
   logic [ChanW-1:0] pix_green;
   logic [ChanW-1:0] pix_blue;

   modport source (output valid, output pix_red, output pix_green, output pix_blue,
                   input ready);
   modport sink   (input valid, input pix_red, input pix_green, input pix_blue,
                   output ready);
endinterface

### hdl/rkf_rsp_if.sv
interface rkf_rsp_if import rkf_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CoordW-1:0] out_row;
   logic [CoordW-1:0] out_col;
   logic [ChanW-1:0]  out_red;
   logic [ChanW-1:0]  out_green;
   logic [ChanW-1:0]  out_blue;
   logic              last_in_run;

   modport source (output valid, output out_row, output out_col, output out_red,
                   output out_green, output out_blue, output last_in_run,
                   input ready);
   modport sink   (input valid, input out_row, input out_col, input out_red,
                   input out_green, input out_blue, input last_in_run,
                   output ready);
endinterface

### hdl/rgb_3x3_kernel_filter_unit.sv
// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          pix_red, pix_green, pix_blue
// rsp_ch    out  valid/ready          out_row, out_col, out_red/green/blue, last_in_run
// csr_*     in   csr_wr_en (no wait)  csr_index, csr_wdata
//
// One transaction per clock while rsp_ch is ready and each input pixel causes at most one
// result; a pixel that causes two results (a delayed filtered pixel plus itself) stays in
// the kernel stage until both are sent. The single result register sets this figure.
// Path: accept -> line-store read + kernel-stage register -> result register -> rsp valid.
// Reset (synchronous) clears the raster counters, pipeline valids and registers to
// their defaults; the line store and window need no clearing.
// A stalled rsp side holds a kernel-stage pixel that has a result to send, dropping req_ch.ready.
module rgb_3x3_kernel_filter_unit import rkf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   rkf_req_if.sink             req_ch,
   rkf_rsp_if.source           rsp_ch,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   // Configuration registers
   cfg_type cfg_ff, cfg_in;

   // Scan stage
   scan_type  scan;
   logic      req_accept;
   pixel_type req_pix;

   // Kernel stage
   logic      s1_valid_ff, s1_valid_in;
   scan_type  s1_info_ff;
   pixel_type s1_pix_ff;
   logic      done_a_ff, done_a_in;
   logic      s1_adv;

   // Line store and forwarding of a same-address write
   pixel_type line0_rd, line1_rd;
   logic      byp_ff;
   pixel_type byp_line0_ff, byp_line1_ff;
   pixel_type col_px [3];

   // Window: three rows, two older columns
   pixel_type win_ff [3][2];
   pixel_type nb [9];
   pixel_type filt_px;

   // Result stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CoordW-1:0] rsp_row_ff, rsp_col_ff;
   pixel_type         rsp_pix_ff;
   logic              rsp_last_ff;
   logic              out_free, pending, sel_a, emit_last, emit;

   // ---------------- configuration ----------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            RegFilterMode:  cfg_in.filter_mode  = csr_wdata[ModeW-1:0];
            RegImageWidth:  cfg_in.image_width  = csr_wdata[DimW-1:0];
            RegImageHeight: cfg_in.image_height = csr_wdata[DimW-1:0];
            RegSelLeft:     cfg_in.sel_left     = csr_wdata[SelW-1:0];
            RegSelTop:      cfg_in.sel_top      = csr_wdata[SelW-1:0];
            RegSelRight:    cfg_in.sel_right    = csr_wdata[DimW-1:0];
            RegSelBottom:   cfg_in.sel_bottom   = csr_wdata[DimW-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode  <= ModeEdge;
         cfg_ff.image_width  <= DimW'(4096);
         cfg_ff.image_height <= DimW'(4096);
         cfg_ff.sel_left     <= '0;
         cfg_ff.sel_top      <= '0;
         cfg_ff.sel_right    <= DimW'(4096);
         cfg_ff.sel_bottom   <= DimW'(4096);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- scan: raster position and region flags ----------------
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_pix      = '{red: req_ch.pix_red, green: req_ch.pix_green,
                           blue: req_ch.pix_blue};

   rkf_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .cfg     (cfg_ff),
      .info    (scan)
   );

   // ---------------- line store: two rows, read on accept, written on advance -----
   rkf_ram #(.Width(PixW), .Depth(MaxWidth)) u_line0 (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_info_ff.col),
      .wr_data (col_px[1]),
      .rd_en   (req_accept),
      .rd_addr (scan.col),
      .rd_data (line0_rd)
   );

   rkf_ram #(.Width(PixW), .Depth(MaxWidth)) u_line1 (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_info_ff.col),
      .wr_data (s1_pix_ff),
      .rd_en   (req_accept),
      .rd_addr (scan.col),
      .rd_data (line1_rd)
   );

   // The RAM reads old data when the leaving pixel writes the address just read
   // (one-pixel rows); capture the written words and use them instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (req_accept) begin
         byp_ff <= s1_adv && (s1_info_ff.col == scan.col);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byp_line0_ff <= col_px[1];
         byp_line1_ff <= s1_pix_ff;
      end
   end

   assign col_px[0] = byp_ff ? byp_line0_ff : line0_rd;
   assign col_px[1] = byp_ff ? byp_line1_ff : line1_rd;
   assign col_px[2] = s1_pix_ff;

   // ---------------- kernel stage ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= scan;
         s1_pix_ff  <= req_pix;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nb[3*k]     = win_ff[k][0];
         nb[3*k + 1] = win_ff[k][1];
         nb[3*k + 2] = col_px[k];
      end
   end

   rkf_kernel u_kernel (
      .mode   (cfg_ff.filter_mode),
      .nb     (nb),
      .result (filt_px)
   );

   // Shift the window one column as the pixel leaves the stage
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= col_px[k];
         end
      end
   end

   // Result sequencing: delayed filtered pixel first, then the pass-through pixel
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ch.ready;
      sel_a     = s1_info_ff.filt_prev && !done_a_ff;
      pending   = sel_a || !s1_info_ff.filt_cur;
      emit_last = sel_a ? s1_info_ff.filt_cur : 1'b1;
      emit      = s1_valid_ff && pending && out_free;
      s1_adv    = s1_valid_ff && (!pending || (out_free && emit_last));

      s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

      done_a_in = done_a_ff;
      if (s1_adv) begin
         done_a_in = 1'b0;
      end else if (emit && sel_a) begin
         done_a_in = 1'b1;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         done_a_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         done_a_ff    <= done_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_last_ff <= emit_last;
         if (sel_a) begin
            rsp_row_ff <= CoordW'(s1_info_ff.row - RowW'(1));
            rsp_col_ff <= CoordW'(s1_info_ff.col - ColW'(1));
            rsp_pix_ff <= filt_px;
         end else begin
            rsp_row_ff <= CoordW'(s1_info_ff.row);
            rsp_col_ff <= CoordW'(s1_info_ff.col);
            rsp_pix_ff <= s1_pix_ff;
         end
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_row     = rsp_row_ff;
   assign rsp_ch.out_col     = rsp_col_ff;
   assign rsp_ch.out_red     = rsp_pix_ff.red;
   assign rsp_ch.out_green   = rsp_pix_ff.green;
   assign rsp_ch.out_blue    = rsp_pix_ff.blue;
   assign rsp_ch.last_in_run = rsp_last_ff;

   // ---------------- assertions ----------------
   // The first of two results was sent only for a pixel that really has two
   a_done_a_pair: assert property (@(posedge clock) disable iff (reset)
      done_a_ff |-> (s1_valid_ff && s1_info_ff.filt_prev && !s1_info_ff.filt_cur))
      else $error("first-result flag set without a two-result pixel");

   // Sending the filtered result of a two-result pixel keeps the pixel in the stage
   a_hold_second: assert property (@(posedge clock) disable iff (reset)
      (emit && sel_a && !s1_info_ff.filt_cur) |=> (s1_valid_ff && done_a_ff))
      else $error("pixel left the stage before its pass-through result");

   // A delayed filtered pixel is flagged only for an arriving pixel off the top row and left column
   a_prev_inside: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_info_ff.filt_prev) |->
      (s1_info_ff.row != '0 && s1_info_ff.col != '0))
      else $error("filtered neighbor outside the image");

endmodule

### hdl/rkf_ram.sv
module rkf_ram #(
   parameter int Width = 24,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rkf_scan.sv
module rkf_scan import rkf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cfg_type  cfg,
   output scan_type info
);

   logic [RowW-1:0] row_ff, row_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [DimW-1:0] w_eff, h_eff;
   logic [DimW-1:0] top_b, left_b, bot_b, rgt_b;
   logic [DimW-1:0] row_x, col_x;

   function automatic logic in_region(input logic [DimW-1:0] r, input logic [DimW-1:0] c,
                                      input logic [DimW-1:0] t, input logic [DimW-1:0] b,
                                      input logic [DimW-1:0] l, input logic [DimW-1:0] rt);
      return (r >= t) && (r < b) && (c >= l) && (c < rt);
   endfunction

   always_comb begin
      // Zero counts as one, oversize clips to MaxWidth (the line-store size) and MaxHeight
      if (cfg.image_width == '0) begin
         w_eff = DimW'(1);
      end else if (cfg.image_width > DimW'(MaxWidth)) begin
         w_eff = DimW'(MaxWidth);
      end else begin
         w_eff = cfg.image_width;
      end
      if (cfg.image_height == '0) begin
         h_eff = DimW'(1);
      end else if (cfg.image_height > DimW'(MaxHeight)) begin
         h_eff = DimW'(MaxHeight);
      end else begin
         h_eff = cfg.image_height;
      end

      // Shrink the selection to leave out the image border
      top_b  = (cfg.sel_top  == '0) ? DimW'(1) : DimW'(cfg.sel_top);
      left_b = (cfg.sel_left == '0) ? DimW'(1) : DimW'(cfg.sel_left);
      bot_b  = (cfg.sel_bottom < h_eff - DimW'(1)) ? cfg.sel_bottom : h_eff - DimW'(1);
      rgt_b  = (cfg.sel_right  < w_eff - DimW'(1)) ? cfg.sel_right  : w_eff - DimW'(1);

      row_x = DimW'(row_ff);
      col_x = DimW'(col_ff);

      info.row       = row_ff;
      info.col       = col_ff;
      info.filt_cur  = in_region(row_x, col_x, top_b, bot_b, left_b, rgt_b);
      info.filt_prev = (row_ff != '0) && (col_ff != '0) &&
                       in_region(row_x - DimW'(1), col_x - DimW'(1),
                                 top_b, bot_b, left_b, rgt_b);

      // Raster advance
      row_in = row_ff;
      col_in = col_ff;
      if (advance) begin
         if (col_x + DimW'(1) >= w_eff) begin
            col_in = '0;
            if (row_x + DimW'(1) >= h_eff) begin
               row_in = '0;
            end else begin
               row_in = row_ff + RowW'(1);
            end
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

### hdl/rkf_kernel.sv
module rkf_kernel import rkf_pkg::*; (
   input  logic [ModeW-1:0] mode,
   input  pixel_type        nb [9],
   output pixel_type        result
);

   function automatic logic [ChanW-1:0] filt_chan(input logic [ModeW-1:0] m,
                                                  input logic [ChanW-1:0] v [9]);
      logic signed [SumW-1:0] sum;
      logic signed [SumW-1:0] res;
      logic        [DimW-1:0] x;
      logic        [ProdW-1:0] prod;
      logic        [ChanW-1:0] q;
      sum = '0;
      for (int i = 0; i < 9; i++) begin
         sum = sum + SumW'(KernelTable[m][i]) * $signed({(SumW-ChanW)'(0), v[i]});
      end
      case (m)
         ModeBox: begin
            // round(sum / 9) == floor((sum + 4) / 9)
            x    = DimW'(sum) + DimW'(4);
            prod = ProdW'(x) * ProdW'(BoxRecip);
            res  = (sum < 0) ? '0 : SumW'(prod[ProdW-1:BoxShift]);
         end
         ModeGauss: begin
            res = (sum < 0) ? '0 : ((sum + SumW'(8)) >>> 4);
         end
         default: begin
            res = sum;
         end
      endcase
      if (res < 0) begin
         q = '0;
      end else if (res > SumW'(255)) begin
         q = '1;
      end else begin
         q = res[ChanW-1:0];
      end
      return q;
   endfunction

   always_comb begin
      logic [ChanW-1:0] r_v [9];
      logic [ChanW-1:0] g_v [9];
      logic [ChanW-1:0] b_v [9];
      for (int i = 0; i < 9; i++) begin
         r_v[i] = nb[i].red;
         g_v[i] = nb[i].green;
         b_v[i] = nb[i].blue;
      end
      result.red   = filt_chan(mode, r_v);
      result.green = filt_chan(mode, g_v);
      result.blue  = filt_chan(mode, b_v);
   end

endmodule
